// ----- src/mfbp_pkg.sv -----
`default_nettype none

package mfbp_pkg;

   // Widths of the transfer fields
   localparam int FUNC_W       = 2;
   localparam int CODE_W       = 24;
   localparam int LEN_W        = 5;
   localparam int BYTE_W       = 8;
   localparam int BCOUNT_W     = 20;
   localparam int TBITS_W      = 23;

   // Emitted-byte counter width (wraps at this width)
   localparam int COUNT_BITS   = 20;

   // Accumulator geometry
   localparam int ACC_W        = 32;
   localparam int FILL_W       = 5;
   localparam int MAX_CODE_LEN = 24;

   // Packed bus widths
   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 56;

   // Item functions
   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_FLUSH   = 2'd1,
      FUNC_RESTART = 2'd2,
      FUNC_QUERY   = 2'd3
   } func_type;

   // Commands to the accumulator unit
   typedef struct packed {
      logic merge;   // append a code below the held bits
      logic pop;     // drop the top byte, shift up by eight
   } acc_cmd_type;

endpackage : mfbp_pkg

`default_nettype wire

// ----- src/msb_first_bit_packer.sv -----
// MSB-first bit packer.
// Input stream (req_*): one transfer per item carrying func, code and
// code_length. A write appends the low code_length bits (saturated to 24)
// below the held bits; flush emits the pending partial byte zero padded;
// restart zeroes the byte count; query only reports counts.
// Output stream (rsp_*): one transfer per emitted byte, or a single
// transfer with tuser (byte_valid) low when an item emits no byte. tlast
// marks the final transfer of an item. All transfers of one item carry the
// byte count and total bit count after the whole item.
// Timing: an item is taken, then each result is loaded into the output
// register one per cycle while the receiver is not stalling; an item that
// emits no byte still loads one result. The rate is set by the single
// accumulator shifter that pops one byte per cycle, held while stalled.
// req_tready is high only while the sequencer is idle; the next item is
// taken while the last result still sits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears the accumulator, fill and byte count; no clearing pass.
`default_nettype none

module msb_first_bit_packer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [1:0] func, [25:2] code, [30:26] code_length, [31] zero
   input  wire logic [mfbp_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] data_byte, [27:8] byte_count, [50:28] total_bits, [55:51] zero
   output logic      [mfbp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] byte_valid
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);
   import mfbp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EMIT = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [1:0]               rem_ff, rem_in;
   logic                     pop_en_ff, pop_en_in;

   logic                     out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]        out_byte_ff, out_byte_in;
   logic                     out_bvalid_ff, out_bvalid_in;
   logic                     out_last_ff, out_last_in;
   logic [BCOUNT_W-1:0]      out_bcount_ff, out_bcount_in;
   logic [TBITS_W-1:0]       out_tbits_ff, out_tbits_in;

   func_type                 req_func;
   logic [CODE_W-1:0]        req_code;
   logic [LEN_W-1:0]         req_len;
   logic                     req_xfer;
   logic                     out_free;
   logic                     load_out;

   acc_cmd_type              acc_cmd;
   logic [BYTE_W-1:0]        acc_top;
   logic [FILL_W-1:0]        acc_fill;
   logic [FILL_W-1:0]        acc_merge_fill;
   logic [31:0]              cnt_ext;

   // Unpack the input transfer
   assign req_func = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_code = req_tdata[FUNC_W +: CODE_W];
   assign req_len  = req_tdata[FUNC_W+CODE_W +: LEN_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign load_out   = (state_ff == S_EMIT) && out_free;

   mfbp_acc_unit u_acc (
      .clock       (clock),
      .reset       (reset),
      .cmd         (acc_cmd),
      .code        (req_code),
      .code_length (req_len),
      .top_byte    (acc_top),
      .fill        (acc_fill),
      .merge_fill  (acc_merge_fill)
   );

   assign cnt_ext = 32'(cnt_ff);

   // Sequencer: take an item, then hand out its results one per cycle while the output register is free
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      pop_en_in = pop_en_ff;
      acc_cmd   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in  = S_EMIT;
               pop_en_in = 1'b0;
               rem_in    = 2'd0;
               case (req_func)
                  FUNC_WRITE: begin
                     acc_cmd.merge = 1'b1;
                     rem_in        = acc_merge_fill[4:3];
                     pop_en_in     = 1'b1;
                     cnt_in        = cnt_ff + COUNT_BITS'(acc_merge_fill[4:3]);
                  end
                  FUNC_FLUSH: begin
                     if (acc_fill != '0) begin
                        rem_in = 2'd1;
                        cnt_in = cnt_ff + COUNT_BITS'(1);
                     end
                  end
                  FUNC_RESTART: begin
                     cnt_in = '0;
                  end
                  default: begin
                     cnt_in = cnt_ff;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               if (rem_ff != 2'd0) begin
                  acc_cmd.pop = pop_en_ff;
                  rem_in      = rem_ff - 2'd1;
               end
               if (rem_ff <= 2'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load the next result, hold while stalled
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;
      out_bcount_in = out_bcount_ff;
      out_tbits_in  = out_tbits_ff;
      if (load_out) begin
         out_valid_in  = 1'b1;
         out_bvalid_in = (rem_ff != 2'd0);
         out_byte_in   = (rem_ff != 2'd0) ? acc_top : '0;
         out_last_in   = (rem_ff <= 2'd1);
         out_bcount_in = cnt_ext[BCOUNT_W-1:0];
         out_tbits_in  = {cnt_ext[BCOUNT_W-1:0], acc_fill[2:0]};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         pop_en_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         pop_en_ff    <= pop_en_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
      out_bcount_ff <= out_bcount_in;
      out_tbits_ff  <= out_tbits_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_bvalid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'b0, out_tbits_ff, out_bcount_ff, out_byte_ff};

   // Fill stays below one byte whenever a new item may be taken
   a_idle_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (acc_fill[4:3] == 2'b00))
      else $error("fill holds a complete byte while idle");

   // A taken item always moves the sequencer into result hand-out
   a_take_emit: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_EMIT))
      else $error("item taken without entering emit");

   // A flush hands out at most one byte and never shifts
   a_flush_one: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT) && !pop_en_ff) |-> (rem_ff <= 2'd1))
      else $error("non-shifting item with more than one byte");

   // The final result of an item returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (load_out && (rem_ff <= 2'd1)) |=> (state_ff == S_IDLE) && rsp_tlast)
      else $error("final result did not end the item");

endmodule : msb_first_bit_packer

`default_nettype wire

// ----- src/mfbp_acc_unit.sv -----
`default_nettype none

module mfbp_acc_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mfbp_pkg::acc_cmd_type           cmd,
   input  wire logic [mfbp_pkg::CODE_W-1:0]     code,
   input  wire logic [mfbp_pkg::LEN_W-1:0]      code_length,
   output logic      [mfbp_pkg::BYTE_W-1:0]     top_byte,
   output logic      [mfbp_pkg::FILL_W-1:0]     fill,
   output logic      [mfbp_pkg::FILL_W-1:0]     merge_fill
);
   import mfbp_pkg::*;

   logic [ACC_W-1:0]  acc_ff,  acc_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0]  len_sat;
   logic [CODE_W-1:0] code_mask;
   logic [ACC_W-1:0]  code_ext;
   logic [5:0]        merge_sh;

   // Saturate the length and mask off unused code bits
   always_comb begin
      len_sat   = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_length;
      code_mask = ~({CODE_W{1'b1}} << len_sat);
      code_ext  = ACC_W'(code & code_mask);
      merge_sh  = 6'd32 - 6'(len_sat) - 6'(fill_ff[2:0]);
      merge_fill = FILL_W'(fill_ff[2:0]) + len_sat;
   end

   // Shared shifter: merge a code or pop the top byte
   always_comb begin
      acc_in  = acc_ff;
      fill_in = fill_ff;
      if (cmd.merge) begin
         acc_in  = acc_ff | (code_ext << merge_sh);
         fill_in = merge_fill;
      end else if (cmd.pop) begin
         acc_in  = acc_ff << BYTE_W;
         fill_in = fill_ff - FILL_W'(BYTE_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         fill_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
      end
   end

   assign top_byte = acc_ff[ACC_W-1 -: BYTE_W];
   assign fill     = fill_ff;

endmodule : mfbp_acc_unit

`default_nettype wire

// ----- verif/msb_first_bit_packer_test.sv -----
`default_nettype none

module msb_first_bit_packer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mfbp_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 390;

   // One input item as the block sees it
   typedef struct {
      func_type          func;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } code_item_type;

   // One output transfer as the block should produce it
   typedef struct {
      logic [BYTE_W-1:0]   data_byte;
      logic                byte_valid;
      logic                last;
      logic [BCOUNT_W-1:0] byte_count;
      logic [TBITS_W-1:0]  total_bits;
   } packed_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire logic             req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   wire logic             rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire logic [RSP_DATA_W-1:0] rsp_tdata;
   wire logic             rsp_tuser;
   wire logic             rsp_tlast;

   // Items waiting to be sent, and results still owed by the block
   code_item_type     code_items[$];
   packed_result_type owed_results[$];

   // Shadow copy of the packer state
   logic [ACC_W-1:0]      shadow_acc   = '0;
   logic [FILL_W-1:0]     shadow_fill  = '0;
   logic [COUNT_BITS-1:0] shadow_count = '0;

   // Run statistics
   int mismatches      = 0;
   int items_taken     = 0;
   int writes_taken    = 0;
   int flushes_taken   = 0;
   int restarts_taken  = 0;
   int queries_taken   = 0;
   int results_checked = 0;
   int bytes_checked   = 0;
   int cycle_count     = 0;

   msb_first_bit_packer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic add_item(input func_type func, input logic [CODE_W-1:0] code,
                           input logic [LEN_W-1:0] len);
      code_item_type it;
      it.func = func;
      it.code = code;
      it.len  = len;
      code_items.push_back(it);
   endtask

   // Append one item to the shadow packer and queue the results it owes
   task automatic pack_into_shadow(input code_item_type it);
      int unsigned    eff_len;
      logic [ACC_W-1:0] mask;
      logic [BYTE_W-1:0] popped [3];
      int             n;
      packed_result_type r;
      n = 0;
      items_taken++;
      case (it.func)
         FUNC_WRITE: begin
            writes_taken++;
            eff_len = (it.len > MAX_CODE_LEN) ? MAX_CODE_LEN : it.len;
            shadow_fill = shadow_fill & 5'd7;
            if (eff_len != 0) begin
               mask = (32'd1 << eff_len) - 32'd1;
               shadow_acc = shadow_acc |
                  (({8'd0, it.code} & mask) << (ACC_W - eff_len - shadow_fill));
            end
            shadow_fill = shadow_fill + FILL_W'(eff_len);
            // pop every complete top byte, at most three
            while (shadow_fill > 5'd7 && n < 3) begin
               popped[n]    = shadow_acc[ACC_W-1 -: BYTE_W];
               shadow_acc   = shadow_acc << 8;
               shadow_fill  = shadow_fill - 5'd8;
               shadow_count = shadow_count + COUNT_BITS'(1);
               n++;
            end
         end
         FUNC_FLUSH: begin
            flushes_taken++;
            // partial byte goes out padded; accumulator and fill stay
            if (shadow_fill != 0) begin
               popped[0]    = shadow_acc[ACC_W-1 -: BYTE_W];
               shadow_count = shadow_count + COUNT_BITS'(1);
               n = 1;
            end
         end
         FUNC_RESTART: begin
            restarts_taken++;
            shadow_count = '0;
         end
         default: queries_taken++;
      endcase
      r.byte_count = shadow_count[BCOUNT_W-1:0];
      r.total_bits = {shadow_count[TBITS_W-4:0], 3'b000} + TBITS_W'(shadow_fill);
      if (n == 0) begin
         r.data_byte  = '0;
         r.byte_valid = 1'b0;
         r.last       = 1'b1;
         owed_results.push_back(r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.data_byte  = popped[k];
            r.byte_valid = 1'b1;
            r.last       = (k == n - 1);
            owed_results.push_back(r);
         end
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
   endtask

   // Driver: bursts of transfers separated by random gaps
   int         burst_left = 0;
   int         gap_left   = 0;
   code_item_type on_bus;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready)
            pack_into_shadow(on_bus);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (code_items.size() != 0) begin
               on_bus = code_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, on_bus.len, on_bus.code, on_bus.func};
               if (burst_left == 0)
                  burst_left = $urandom_range(1, 24);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: receiver stall pattern and result check
   int   ready_mode = 0;
   int   span_left  = 0;
   int   phase_cnt  = 0;
   logic ready_nxt;
   packed_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transfer, expected none, actual data 0x%0h",
                        $time, rsp_tdata);
            end else begin
               want = owed_results.pop_front();
               results_checked++;
               if (rsp_tuser)
                  bytes_checked++;
               if (rsp_tdata[7:0] !== want.data_byte)
                  flag_mismatch("data_byte", 32'(want.data_byte), 32'(rsp_tdata[7:0]));
               if (rsp_tuser !== want.byte_valid)
                  flag_mismatch("byte_valid", 32'(want.byte_valid), 32'(rsp_tuser));
               if (rsp_tlast !== want.last)
                  flag_mismatch("last", 32'(want.last), 32'(rsp_tlast));
               if (rsp_tdata[27:8] !== want.byte_count)
                  flag_mismatch("byte_count", 32'(want.byte_count), 32'(rsp_tdata[27:8]));
               if (rsp_tdata[50:28] !== want.total_bits)
                  flag_mismatch("total_bits", 32'(want.total_bits), 32'(rsp_tdata[50:28]));
            end
         end
         // switch between always ready, light, heavy and periodic stalls
         if (span_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            span_left  = $urandom_range(20, 120);
         end else begin
            span_left--;
         end
         phase_cnt++;
         case (ready_mode)
            0:       ready_nxt = 1'b1;
            1:       ready_nxt = ($urandom_range(0, 3) != 0);
            2:       ready_nxt = ($urandom_range(0, 3) == 0);
            default: ready_nxt = ((phase_cnt % 5) < 2);
         endcase
         rsp_tready <= ready_nxt;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, owed_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int sel;
      logic [LEN_W-1:0] len;
      int total_items;

      // Directed: extremes, every function, saturation, repeated flush
      add_item(FUNC_WRITE,   24'h000000, 5'd0);
      add_item(FUNC_WRITE,   24'hffffff, 5'd24);
      add_item(FUNC_WRITE,   24'h000005, 5'd3);
      add_item(FUNC_FLUSH,   24'h000000, 5'd0);
      add_item(FUNC_FLUSH,   24'hffffff, 5'd31);
      add_item(FUNC_WRITE,   24'h00001f, 5'd5);
      add_item(FUNC_FLUSH,   24'h000000, 5'd0);
      add_item(FUNC_WRITE,   24'h00007f, 5'd7);
      add_item(FUNC_WRITE,   24'haaaaaa, 5'd24);
      add_item(FUNC_WRITE,   24'h555555, 5'd31);
      add_item(FUNC_WRITE,   24'h123456, 5'd25);
      add_item(FUNC_QUERY,   24'hffffff, 5'd31);
      add_item(FUNC_RESTART, 24'hffffff, 5'd31);
      add_item(FUNC_QUERY,   24'h000000, 5'd0);
      add_item(FUNC_WRITE,   24'h000000, 5'd1);
      add_item(FUNC_WRITE,   24'h000001, 5'd1);
      add_item(FUNC_WRITE,   24'hffffff, 5'd0);
      add_item(FUNC_WRITE,   24'h000000, 5'd24);
      add_item(FUNC_WRITE,   24'hffffff, 5'd8);
      add_item(FUNC_FLUSH,   24'h000000, 5'd0);
      add_item(FUNC_RESTART, 24'h000000, 5'd0);
      add_item(FUNC_WRITE,   24'h0000ff, 5'd6);
      add_item(FUNC_FLUSH,   24'h000000, 5'd0);
      add_item(FUNC_WRITE,   24'h00000f, 5'd4);
      add_item(FUNC_QUERY,   24'h000000, 5'd0);

      // Random: mostly writes, some saturated lengths, sparse restarts
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sel = $urandom_range(0, 99);
         len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(25, 31))
                                           : LEN_W'($urandom_range(0, 24));
         if (sel < 64)
            add_item(FUNC_WRITE, CODE_W'($urandom()), len);
         else if (sel < 80)
            add_item(FUNC_FLUSH, CODE_W'($urandom()), len);
         else if (sel < 86)
            add_item(FUNC_RESTART, CODE_W'($urandom()), len);
         else
            add_item(FUNC_QUERY, CODE_W'($urandom()), len);
      end
      total_items = code_items.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drain: every item taken, every owed result seen, then a short settle
      while (items_taken < total_items || owed_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d items: %0d writes, %0d flushes, %0d restarts, %0d queries.",
               items_taken, writes_taken, flushes_taken, restarts_taken, queries_taken);
      $display("Checked %0d result transfers, %0d of them carrying bytes; %0d mismatches.",
               results_checked, bytes_checked, mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
src/mfbp_pkg.sv
src/mfbp_acc_unit.sv
src/msb_first_bit_packer.sv
verif/msb_first_bit_packer_test.sv
